// ===== rtl/icc_pkg.sv =====
// interval coverage cache: shared types, constants and state codes
// used by icc_ctrl, icc_datapath and interval_coverage_cache_core; no dependencies
package icc_pkg;

  localparam int unsigned MaxIntervals = 64;
  localparam logic [31:0] ThresholdReset = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [47:0] offset;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        cached;
    logic        overflow;
    logic [48:0] bytes_in_use;
    logic [47:0] writes_seen;
    logic [63:0] bytes_written;
    logic [47:0] writes_cached;
    logic [63:0] bytes_cached;
    logic [47:0] reads_seen;
    logic [63:0] bytes_read;
    logic [47:0] reads_hit;
    logic [63:0] bytes_hit;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_DECIDE,
    ST_SCAN2,
    ST_STORE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, update counters
    logic scan1;     // pass one step: find slot / hit
    logic scan2;     // pass two step: merge and invalidate
    logic store;     // write merged range
    logic restart;   // reset scan index
    logic respond;   // drive result strobe
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // scan index at final entry
    logic record;    // write within threshold
    logic is_read;
    logic have_slot; // slot found after pass one
    logic hit;
  } sts_t;

endpackage

// ===== rtl/interval_coverage_cache_core.sv =====
// interval coverage cache top level: threshold register, controller, datapath
// depends on icc_pkg, icc_ctrl, icc_datapath
//
// A request is taken when start_i is high and busy_o low. A read scans the
// table one entry per cycle and stops at the first containing range. A
// recorded write runs two full passes (slot search, then merge) plus decide
// and store; a recorded write that finds no slot is dropped after the first
// pass and decide, and a write above the threshold goes straight from the
// first scan step to the result. The scan rate is set by the single
// registered table read port. The result shows on rsp_o for one cycle with
// done_o high; it cannot be held off. The table needs no clearing pass after
// reset.
module interval_coverage_cache_core #(
  parameter int unsigned MaxIntervals = icc_pkg::MaxIntervals
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  icc_pkg::req_t req_i,
  output logic          done_o,
  output icc_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i
);

  logic [31:0]   threshold_q;
  icc_pkg::cmd_t cmd;
  icc_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= icc_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  icc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  icc_datapath #(.MaxIntervals(MaxIntervals)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (req_i),
    .threshold_i(threshold_q),
    .rsp_o      (rsp_o)
  );

  assign done_o = cmd.respond;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back to back result strobes");
  a_excl_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.cached && rsp_o.overflow) && !(rsp_o.hit && rsp_o.cached))
    else $error("conflicting result flags");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result while idle");

endmodule

// ===== rtl/icc_ctrl.sv =====
// interval coverage cache controller: sequences the two table passes
// depends on icc_pkg
module icc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  icc_pkg::sts_t  sts_i,
  output icc_pkg::cmd_t  cmd_o
);

  icc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != icc_pkg::ST_IDLE);
    unique case (state_q)
      icc_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.restart = 1'b1;
          state_d       = icc_pkg::ST_SCAN1;
        end
      end
      icc_pkg::ST_SCAN1: begin
        cmd_o.scan1 = 1'b1;
        if (sts_i.last || (sts_i.is_read && sts_i.hit) ||
            (!sts_i.is_read && !sts_i.record)) begin
          state_d = sts_i.is_read || !sts_i.record ? icc_pkg::ST_DONE
                                                   : icc_pkg::ST_DECIDE;
        end
      end
      icc_pkg::ST_DECIDE: begin
        cmd_o.restart = 1'b1;
        state_d = sts_i.have_slot ? icc_pkg::ST_SCAN2 : icc_pkg::ST_DONE;
      end
      icc_pkg::ST_SCAN2: begin
        cmd_o.scan2 = 1'b1;
        if (sts_i.last) state_d = icc_pkg::ST_STORE;
      end
      icc_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = icc_pkg::ST_DONE;
      end
      icc_pkg::ST_DONE: begin
        cmd_o.respond = 1'b1;
        state_d       = icc_pkg::ST_IDLE;
      end
      default: state_d = icc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/icc_datapath.sv =====
// interval coverage cache datapath: range table, merge logic, counters
// depends on icc_pkg
module icc_datapath #(
  parameter int unsigned MaxIntervals = icc_pkg::MaxIntervals
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  icc_pkg::cmd_t  cmd_i,
  output icc_pkg::sts_t  sts_o,
  input  icc_pkg::req_t  req_i,
  input  logic [31:0]    threshold_i,
  output icc_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxIntervals - 1);

  logic [47:0] start_mem [MaxIntervals];
  logic [48:0] end_mem   [MaxIntervals];
  logic [MaxIntervals-1:0] valid_q;

  logic        is_read_q, record_q, hit_q, slot_ok_q, free_ok_q, cached_q, ovf_q;
  logic [47:0] lo_q;
  logic [48:0] hi_q, new_lo_q, new_hi_q;
  logic [31:0] len_q;
  logic [IdxW-1:0] idx_q, idx_d, slot_q, free_q;
  logic [49:0] removed_q;
  logic [48:0] covered_q;
  logic [47:0] wr_cnt_q, wc_cnt_q, rd_cnt_q, hit_cnt_q;
  logic [63:0] wr_sum_q, wc_sum_q, rd_sum_q, hit_sum_q;
  logic [47:0] rd_start_q;
  logic [48:0] rd_end_q;

  // entry at scan index
  logic [47:0] e_start;
  logic [48:0] e_end;
  logic        e_valid, touch, contain;

  // table read is registered: the entry for idx_d is fetched so it is ready when idx_q reaches it
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.restart) begin
      idx_d = '0;
    end else if (cmd_i.scan1 || cmd_i.scan2) begin
      idx_d = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);
    end
  end

  assign e_start = rd_start_q;
  assign e_end   = rd_end_q;
  assign e_valid = valid_q[idx_q];
  assign touch   = e_valid && ({1'b0, e_start} <= hi_q) && (e_end >= {1'b0, lo_q});
  assign contain = e_valid && (e_start <= lo_q) && (e_end >= hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      start_mem[slot_q] <= new_lo_q[47:0];
      end_mem[slot_q]   <= new_hi_q;
    end
    rd_start_q <= start_mem[idx_d];
    rd_end_q   <= end_mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      idx_q     <= '0;
      covered_q <= '0;
      wr_cnt_q  <= '0; wc_cnt_q <= '0; rd_cnt_q <= '0; hit_cnt_q <= '0;
      wr_sum_q  <= '0; wc_sum_q <= '0; rd_sum_q <= '0; hit_sum_q <= '0;
      is_read_q <= 1'b0; record_q <= 1'b0; hit_q <= 1'b0;
      slot_ok_q <= 1'b0; free_ok_q <= 1'b0; cached_q <= 1'b0; ovf_q <= 1'b0;
      lo_q      <= '0; len_q <= '0; hi_q <= '0;
      new_lo_q  <= '0; new_hi_q <= '0; removed_q <= '0;
      slot_q    <= '0; free_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.load) begin
        is_read_q <= req_i.command == icc_pkg::CMD_READ;
        lo_q      <= req_i.offset;
        len_q     <= req_i.length;
        hi_q      <= {1'b0, req_i.offset} + 49'(req_i.length);
        new_lo_q  <= {1'b0, req_i.offset};
        new_hi_q  <= {1'b0, req_i.offset} + 49'(req_i.length);
        record_q  <= 1'b0;
        hit_q     <= 1'b0; slot_ok_q <= 1'b0; free_ok_q <= 1'b0;
        cached_q  <= 1'b0; ovf_q <= 1'b0;
        removed_q <= '0;
        if (req_i.command == icc_pkg::CMD_READ) begin
          rd_cnt_q <= rd_cnt_q + 48'd1;
          rd_sum_q <= rd_sum_q + 64'(req_i.length);
        end else begin
          wr_cnt_q <= wr_cnt_q + 48'd1;
          wr_sum_q <= wr_sum_q + 64'(req_i.length);
          if (req_i.length <= threshold_i) begin
            record_q <= 1'b1;
            wc_cnt_q <= wc_cnt_q + 48'd1;
            wc_sum_q <= wc_sum_q + 64'(req_i.length);
          end
        end
      end
      if (cmd_i.scan1) begin
        if (is_read_q) begin
          if (contain && !hit_q) begin
            hit_q     <= 1'b1;
            hit_cnt_q <= hit_cnt_q + 48'd1;
            hit_sum_q <= hit_sum_q + 64'(len_q);
          end
        end else begin
          // last touching entry wins, first free entry as fallback
          if (touch) begin
            slot_q    <= idx_q;
            slot_ok_q <= 1'b1;
          end
          if (!e_valid && !free_ok_q) begin
            free_q    <= idx_q;
            free_ok_q <= 1'b1;
          end
        end
      end
      if (cmd_i.restart && !cmd_i.load && !slot_ok_q) begin
        slot_q <= free_q;
        if (!free_ok_q) ovf_q <= 1'b1;
      end
      if (cmd_i.scan2) begin
        if (touch) begin
          if ({1'b0, e_start} < new_lo_q) new_lo_q <= {1'b0, e_start};
          if (e_end > new_hi_q) new_hi_q <= e_end;
          removed_q <= removed_q + 50'(e_end - {1'b0, e_start});
          valid_q[idx_q] <= 1'b0;
        end
      end
      if (cmd_i.store) begin
        valid_q[slot_q] <= 1'b1;
        cached_q        <= 1'b1;
        covered_q <= 49'(50'(covered_q) - removed_q + 50'(new_hi_q - new_lo_q));
      end
    end
  end

  assign sts_o.last      = (idx_q == LastIdx);
  assign sts_o.record    = record_q;
  assign sts_o.is_read   = is_read_q;
  assign sts_o.have_slot = slot_ok_q || free_ok_q;
  assign sts_o.hit       = contain;

  always_comb begin
    rsp_o.hit           = hit_q;
    rsp_o.cached        = cached_q;
    rsp_o.overflow      = ovf_q;
    rsp_o.bytes_in_use  = covered_q;
    rsp_o.writes_seen   = wr_cnt_q;
    rsp_o.bytes_written = wr_sum_q;
    rsp_o.writes_cached = wc_cnt_q;
    rsp_o.bytes_cached  = wc_sum_q;
    rsp_o.reads_seen    = rd_cnt_q;
    rsp_o.bytes_read    = rd_sum_q;
    rsp_o.reads_hit     = hit_cnt_q;
    rsp_o.bytes_hit     = hit_sum_q;
  end

endmodule

// ===== verif/tb.sv =====
// testbench for interval_coverage_cache_core: queue-fed request driver, result monitor
// and a behavioral predictor of the range table and counters; depends on icc_pkg
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = icc_pkg::MaxIntervals;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  icc_pkg::req_t req_i;
  logic          done_o;
  icc_pkg::rsp_t rsp_o;
  logic          cfg_we_i;
  logic [31:0]   cfg_wdata_i;

  interval_coverage_cache_core #(.MaxIntervals(Depth)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predicted table and counters
  logic [47:0] tbl_lo [Depth];
  logic [48:0] tbl_hi [Depth];
  logic        tbl_vld [Depth];
  logic [48:0] cov_bytes = '0;
  logic [47:0] n_wr = '0, n_wr_cached = '0, n_rd = '0, n_hit = '0;
  logic [63:0] sum_wr = '0, sum_wr_cached = '0, sum_rd = '0, sum_hit = '0;
  logic [31:0] threshold = icc_pkg::ThresholdReset;

  icc_pkg::req_t pending_q[$];
  icc_pkg::rsp_t expected_q[$];
  int   errors = 0;
  bit   taken = 0;
  int   burst_left = 0;
  int   gap_left = 0;

  initial begin
    for (int i = 0; i < Depth; i++) tbl_vld[i] = 1'b0;
  end

  function automatic icc_pkg::rsp_t predict_access(icc_pkg::req_t r);
    icc_pkg::rsp_t o;
    logic [48:0]   lo, hi, m_lo, m_hi, removed;
    int            slot;
    lo = {1'b0, r.offset};
    hi = lo + 49'(r.length);
    o = '0;
    if (r.command == icc_pkg::CMD_WRITE) begin
      n_wr++;
      sum_wr += 64'(r.length);
      if (r.length <= threshold) begin
        n_wr_cached++;
        sum_wr_cached += 64'(r.length);
        slot = -1;
        for (int i = 0; i < Depth; i++)
          if (tbl_vld[i] && tbl_lo[i] <= hi && tbl_hi[i] >= lo) slot = i;
        if (slot < 0)
          for (int i = Depth - 1; i >= 0; i--)
            if (!tbl_vld[i]) slot = i;
        if (slot < 0) begin
          o.overflow = 1'b1;
        end else begin
          m_lo = lo;
          m_hi = hi;
          removed = '0;
          // absorb every range that overlaps or touches
          for (int i = 0; i < Depth; i++) begin
            if (tbl_vld[i] && tbl_lo[i] <= hi && tbl_hi[i] >= lo) begin
              if ({1'b0, tbl_lo[i]} < m_lo) m_lo = {1'b0, tbl_lo[i]};
              if (tbl_hi[i] > m_hi) m_hi = tbl_hi[i];
              removed += tbl_hi[i] - {1'b0, tbl_lo[i]};
              tbl_vld[i] = 1'b0;
            end
          end
          tbl_lo[slot] = m_lo[47:0];
          tbl_hi[slot] = m_hi;
          tbl_vld[slot] = 1'b1;
          cov_bytes = cov_bytes - removed + (m_hi - m_lo);
          o.cached = 1'b1;
        end
      end
    end else begin
      n_rd++;
      sum_rd += 64'(r.length);
      for (int i = 0; i < Depth; i++)
        if (tbl_vld[i] && tbl_lo[i] <= lo && tbl_hi[i] >= hi) o.hit = 1'b1;
      if (o.hit) begin
        n_hit++;
        sum_hit += 64'(r.length);
      end
    end
    o.bytes_in_use  = cov_bytes;
    o.writes_seen   = n_wr;
    o.bytes_written = sum_wr;
    o.writes_cached = n_wr_cached;
    o.bytes_cached  = sum_wr_cached;
    o.reads_seen    = n_rd;
    o.bytes_read    = sum_rd;
    o.reads_hit     = n_hit;
    o.bytes_hit     = sum_hit;
    return o;
  endfunction

  function automatic icc_pkg::req_t mk(icc_pkg::cmd_e c, logic [47:0] o, logic [31:0] l);
    icc_pkg::req_t r;
    r.command = c;
    r.offset = o;
    r.length = l;
    return r;
  endfunction

  // mostly accesses clustered around base so merges and hits happen
  function automatic icc_pkg::req_t rand_access(logic [47:0] base);
    icc_pkg::cmd_e c;
    c = $urandom_range(0, 1) ? icc_pkg::CMD_READ : icc_pkg::CMD_WRITE;
    if ($urandom_range(0, 4) == 0)
      return mk(c, 48'({$urandom, $urandom}), $urandom);
    return mk(c, base + 48'($urandom_range(0, 2047)),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40));
  endfunction

  task automatic field_check(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
      errors++;
    end
  endtask

  // request accept and result check
  always @(posedge clk_i) begin
    icc_pkg::rsp_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $realtime, rsp_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        field_check("hit", 64'(e.hit), 64'(rsp_o.hit));
        field_check("cached", 64'(e.cached), 64'(rsp_o.cached));
        field_check("overflow", 64'(e.overflow), 64'(rsp_o.overflow));
        field_check("bytes_in_use", 64'(e.bytes_in_use), 64'(rsp_o.bytes_in_use));
        field_check("writes_seen", 64'(e.writes_seen), 64'(rsp_o.writes_seen));
        field_check("bytes_written", e.bytes_written, rsp_o.bytes_written);
        field_check("writes_cached", 64'(e.writes_cached), 64'(rsp_o.writes_cached));
        field_check("bytes_cached", e.bytes_cached, rsp_o.bytes_cached);
        field_check("reads_seen", 64'(e.reads_seen), 64'(rsp_o.reads_seen));
        field_check("bytes_read", e.bytes_read, rsp_o.bytes_read);
        field_check("reads_hit", 64'(e.reads_hit), 64'(rsp_o.reads_hit));
        field_check("bytes_hit", e.bytes_hit, rsp_o.bytes_hit);
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      expected_q.push_back(predict_access(req_i));
      taken = 1;
    end
  end

  // request driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !taken)) begin
      taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_i <= pending_q.pop_front();
        start_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || start_i || expected_q.size() > 0) @(negedge clk_i);
    repeat (2 * Depth + 10) @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    threshold = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty range, touching merges, containment edges, field extremes
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd0, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd0, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd0, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd10, 32'd5));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd15, 32'd5));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd10, 32'd10));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd9, 32'd2));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd19, 32'd2));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd5, 32'd5));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd0, 32'd5));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd0, 32'd20));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, '1, '1));
    pending_q.push_back(mk(icc_pkg::CMD_READ, '1, '1));
    pending_q.push_back(mk(icc_pkg::CMD_READ, '1, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_READ, 48'd1000, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd100, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd100, 32'd0));
    drain();

    // nothing recorded except zero-length writes
    set_threshold(32'd0);
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd200, 32'd0));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd300, 32'd1));
    for (int i = 0; i < 200; i++) pending_q.push_back(rand_access(48'h1000_0000));
    drain();

    set_threshold(32'd100);
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd400, 32'd100));
    pending_q.push_back(mk(icc_pkg::CMD_WRITE, 48'd600, 32'd101));
    for (int i = 0; i < 250; i++) pending_q.push_back(rand_access(48'h1000_0000));
    drain();

    // fill the table with separated ranges until writes overflow
    set_threshold(32'hFFFF_FFFE);
    for (int i = 0; i < 90; i++)
      pending_q.push_back(mk(icc_pkg::CMD_WRITE,
                             48'h8000_0000_0000 + 48'(i * 256) +
                             48'($urandom_range(0, 100)),
                             $urandom_range(0, 50)));
    for (int i = 0; i < 200; i++)
      pending_q.push_back(($urandom_range(0, 1) == 0) ?
        rand_access(48'h8000_0000_0000) : rand_access(48'h1000_0000));
    drain();

    set_threshold(32'hFFFF_FFFF);
    for (int i = 0; i < 300; i++) pending_q.push_back(rand_access(48'h1000_0000));
    drain();

    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0, actual %0d",
               $realtime, expected_q.size(), expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
